// ===== rtl/mcw_pkg.sv =====
package mcw_pkg;

	localparam int MAX_TEXT    = 4096;
	localparam int MAX_PATTERN = 255;
	localparam int TEXT_AW     = $clog2(MAX_TEXT);
	localparam int POS_W       = TEXT_AW + 1;
	localparam int SYM_W       = 8;
	localparam int NEED_W      = $clog2(MAX_PATTERN + 1);
	localparam int HAVE_W      = POS_W;
	localparam int NUM_SYM     = 1 << SYM_W;

	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_PATTERN = 2'd1,
		REQ_TEXT    = 2'd2
	} req_e;

	typedef struct packed {
		logic              clr;
		logic              rd_en;
		logic [SYM_W-1:0]  rd_addr;
		logic              wr_en;
		logic [SYM_W-1:0]  wr_addr;
		logic [NEED_W-1:0] wr_need;
		logic [HAVE_W-1:0] wr_have;
	} tbl_req_t;

	typedef struct packed {
		logic [NEED_W-1:0] need;
		logic [HAVE_W-1:0] have;
	} tbl_rsp_t;

	typedef struct packed {
		logic               en;
		logic               we;
		logic [TEXT_AW-1:0] addr;
		logic [SYM_W-1:0]   wdata;
	} txt_req_t;

endpackage

// ===== rtl/minimum_covering_window.sv =====
// Streaming minimum covering window search. A clear item starts a new job, pattern
// items fill a per-symbol need table, and text items are stored and counted; every
// item returns one result with the shortest window found so far (ties keep the
// earlier one) and a sticky overflow flag. One sequencer drives a need/have table and a
// single-port text memory, one access each per cycle. A clear, ignored or dropped item
// goes straight to its result, a pattern item reads and rewrites its entry, and a text
// item is stored and counted; if it completes the cover, the window start moves past
// surplus symbols, passing each text position at most once per job. The input stalls
// while an item is in work and while an earlier result is still held by a stalled output.
module minimum_covering_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [mcw_pkg::SYM_W-1:0]   symbol,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [mcw_pkg::TEXT_AW-1:0] best_start,
	output logic [mcw_pkg::POS_W-1:0]   best_length,
	output logic                        overflow
);
	import mcw_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_PAT    = 8'b0000_0010,
		ST_TXT    = 8'b0000_0100,
		ST_SCAN   = 8'b0000_1000,
		ST_SCAN_T = 8'b0001_0000,
		ST_SCAN_D = 8'b0010_0000,
		ST_BEST   = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [NEED_W-1:0]  plen_q;
	logic [NEED_W-1:0]  covered_q;
	logic [TEXT_AW-1:0] wb_q;
	logic [TEXT_AW-1:0] end_q;
	logic [POS_W-1:0]   tpos_q;
	logic [POS_W-1:0]   best_len_q;
	logic [TEXT_AW-1:0] best_start_q;
	logic               ovf_q;
	logic [SYM_W-1:0]   sym_q;
	logic [SYM_W-1:0]   c_q;
	logic               out_valid_q;
	logic               found_q;
	logic [TEXT_AW-1:0] out_start_q;
	logic [POS_W-1:0]   out_len_q;
	logic               out_ovf_q;

	tbl_req_t         tbl_req;
	tbl_rsp_t         tbl_rsp;
	txt_req_t         txt_req;
	logic [SYM_W-1:0] txt_rdata;
	logic             accept;
	logic [NEED_W-1:0] covered_nx;
	logic             have_surplus;
	logic [POS_W-1:0] win_len;

	mcw_tables u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rsp    (tbl_rsp)
	);

	mcw_text_mem u_text (
		.clk   (clk),
		.req   (txt_req),
		.rdata (txt_rdata)
	);

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign covered_nx   = (tbl_rsp.have < HAVE_W'(tbl_rsp.need)) ? covered_q + 1'b1 : covered_q;
	assign have_surplus = tbl_rsp.have > HAVE_W'(tbl_rsp.need);
	assign win_len      = POS_W'(end_q) - POS_W'(wb_q) + POS_W'(1);

	always_comb begin
		tbl_req = '0;
		txt_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_CLEAR: tbl_req.clr = 1'b1;
						REQ_PATTERN: begin
							if (tpos_q == '0 && plen_q < NEED_W'(MAX_PATTERN)) begin
								tbl_req.rd_en   = 1'b1;
								tbl_req.rd_addr = symbol;
							end
						end
						REQ_TEXT: begin
							if (tpos_q < POS_W'(MAX_TEXT)) begin
								txt_req.en      = 1'b1;
								txt_req.we      = 1'b1;
								txt_req.addr    = tpos_q[TEXT_AW-1:0];
								txt_req.wdata   = symbol;
								tbl_req.rd_en   = 1'b1;
								tbl_req.rd_addr = symbol;
							end
						end
						default: ;
					endcase
				end
			end
			ST_PAT: begin
				tbl_req.wr_en   = 1'b1;
				tbl_req.wr_addr = sym_q;
				tbl_req.wr_need = tbl_rsp.need + 1'b1;
				tbl_req.wr_have = tbl_rsp.have;
			end
			ST_TXT: begin
				if (tbl_rsp.need != '0) begin
					tbl_req.wr_en   = 1'b1;
					tbl_req.wr_addr = sym_q;
					tbl_req.wr_need = tbl_rsp.need;
					tbl_req.wr_have = tbl_rsp.have + 1'b1;
				end
			end
			ST_SCAN: begin
				if (wb_q < end_q) begin
					txt_req.en   = 1'b1;
					txt_req.addr = wb_q;
				end
			end
			ST_SCAN_T: begin
				tbl_req.rd_en   = 1'b1;
				tbl_req.rd_addr = txt_rdata;
			end
			ST_SCAN_D: begin
				// A surplus copy of a needed symbol leaves the window.
				if (tbl_rsp.need != '0 && have_surplus) begin
					tbl_req.wr_en   = 1'b1;
					tbl_req.wr_addr = c_q;
					tbl_req.wr_need = tbl_rsp.need;
					tbl_req.wr_have = tbl_rsp.have - 1'b1;
				end
			end
			ST_BEST: ;
			ST_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			plen_q       <= '0;
			covered_q    <= '0;
			wb_q         <= '0;
			end_q        <= '0;
			tpos_q       <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			ovf_q        <= 1'b0;
			sym_q        <= '0;
			c_q          <= '0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			out_start_q  <= '0;
			out_len_q    <= '0;
			out_ovf_q    <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sym_q   <= symbol;
						state_q <= ST_EMIT;
						case (req_type)
							REQ_CLEAR: begin
								plen_q       <= '0;
								covered_q    <= '0;
								wb_q         <= '0;
								tpos_q       <= '0;
								best_len_q   <= '0;
								best_start_q <= '0;
								ovf_q        <= 1'b0;
							end
							REQ_PATTERN: begin
								// Pattern symbols after the first text symbol are ignored.
								if (tpos_q == '0) begin
									if (plen_q >= NEED_W'(MAX_PATTERN)) begin
										ovf_q <= 1'b1;
									end else begin
										state_q <= ST_PAT;
									end
								end
							end
							REQ_TEXT: begin
								if (tpos_q >= POS_W'(MAX_TEXT)) begin
									ovf_q <= 1'b1;
								end else begin
									end_q   <= tpos_q[TEXT_AW-1:0];
									tpos_q  <= tpos_q + 1'b1;
									state_q <= ST_TXT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PAT: begin
					plen_q  <= plen_q + 1'b1;
					state_q <= ST_EMIT;
				end
				ST_TXT: begin
					if (tbl_rsp.need == '0) begin
						state_q <= ST_EMIT;
					end else begin
						covered_q <= covered_nx;
						state_q   <= (covered_nx == plen_q) ? ST_SCAN : ST_EMIT;
					end
				end
				ST_SCAN: begin
					state_q <= (wb_q < end_q) ? ST_SCAN_T : ST_BEST;
				end
				ST_SCAN_T: begin
					c_q     <= txt_rdata;
					state_q <= ST_SCAN_D;
				end
				ST_SCAN_D: begin
					if (tbl_rsp.need == '0 || have_surplus) begin
						wb_q    <= wb_q + 1'b1;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_BEST;
					end
				end
				ST_BEST: begin
					if (best_len_q == '0 || win_len < best_len_q) begin
						best_len_q   <= win_len;
						best_start_q <= wb_q;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					out_valid_q <= 1'b1;
					found_q     <= best_len_q != '0;
					out_start_q <= best_start_q;
					out_len_q   <= best_len_q;
					out_ovf_q   <= ovf_q;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign best_start  = out_start_q;
	assign best_length = out_len_q;
	assign overflow    = out_ovf_q;

`ifndef SYNTHESIS
	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == ST_IDLE)
		else $error("item accepted while the sequencer was busy");

	a_covered_bound: assert property (@(posedge clk) disable iff (!arst_n)
		covered_q <= plen_q)
		else $error("covered count exceeds pattern length");

	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BEST |-> wb_q <= end_q)
		else $error("window start passed window end");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> found == (best_length != '0))
		else $error("found flag disagrees with best length");
`endif

endmodule

// ===== rtl/mcw_tables.sv =====
module mcw_tables (
	input  logic              clk,
	input  logic              arst_n,
	input  mcw_pkg::tbl_req_t req,
	output mcw_pkg::tbl_rsp_t rsp
);
	import mcw_pkg::*;

	logic [NEED_W-1:0]  need_mem [NUM_SYM];
	logic [HAVE_W-1:0]  have_mem [NUM_SYM];
	logic [NUM_SYM-1:0] valid_q;
	logic [NEED_W-1:0]  need_rd_q;
	logic [HAVE_W-1:0]  have_rd_q;
	logic               valid_rd_q;

	// Entries not written since the last clear read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clr) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			need_mem[req.wr_addr] <= req.wr_need;
			have_mem[req.wr_addr] <= req.wr_have;
		end
		if (req.rd_en) begin
			need_rd_q  <= need_mem[req.rd_addr];
			have_rd_q  <= have_mem[req.rd_addr];
			valid_rd_q <= valid_q[req.rd_addr];
		end
	end

	assign rsp.need = valid_rd_q ? need_rd_q : '0;
	assign rsp.have = valid_rd_q ? have_rd_q : '0;

endmodule

// ===== rtl/mcw_text_mem.sv =====
module mcw_text_mem (
	input  logic                      clk,
	input  mcw_pkg::txt_req_t         req,
	output logic [mcw_pkg::SYM_W-1:0] rdata
);
	import mcw_pkg::*;

	logic [SYM_W-1:0] mem [MAX_TEXT];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end

endmodule
